/* design/bd2_pkg.sv */
// Package for the 2x2 box-filter downscaler.
// Holds the shared widths, register indexes, reset values and the lane control struct.
// Used by every module in the design folder except bd2_ram.
package bd2_pkg;

	localparam int DEF_MAX_WIDTH  = 2048;
	localparam int DEF_MAX_HEIGHT = 2048;

	localparam int NUM_LANES  = 4;
	localparam int CHAN_W     = 8;
	localparam int SUM_W      = CHAN_W + 1;
	localparam int COORD_W    = 10;
	localparam int SIZE_W     = 12;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = SIZE_W;

	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 56;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 12'd2048;

	typedef struct packed {
		logic load_held;
		logic adv_s1;
	} lane_ctrl_t;

endpackage

/* design/bd2_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; width and depth come from the parameters.
module bd2_ram #(
	parameter int WIDTH  = 36,
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* design/bd2_lane.sv */
// One channel lane of the downscaler: holds the left pixel, forms the pair sum
// and, one stage later, the truncated mean of the 2x2 block.
// Depends on bd2_pkg.
module bd2_lane (
	input  logic                        clk,
	input  bd2_pkg::lane_ctrl_t         ctrl,
	input  logic [bd2_pkg::CHAN_W-1:0]  px,
	input  logic [bd2_pkg::SUM_W-1:0]   upper,
	output logic [bd2_pkg::SUM_W-1:0]   pair,
	output logic [bd2_pkg::CHAN_W-1:0]  avg
);
	import bd2_pkg::*;

	logic [CHAN_W-1:0] held_q;
	logic [SUM_W-1:0]  pair_s1;
	logic [SUM_W:0]    block_sum;

	assign pair      = {1'b0, held_q} + {1'b0, px};
	assign block_sum = {1'b0, upper} + {1'b0, pair_s1};
	assign avg       = block_sum[SUM_W:2];

	always_ff @(posedge clk) begin
		if (ctrl.load_held) begin
			held_q <= px;
		end
		if (ctrl.adv_s1) begin
			pair_s1 <= pair;
		end
	end

endmodule

/* design/bd2_merge.sv */
// Output stage: merges the lane results and the destination coordinates into
// one registered output beat. Depends on bd2_pkg.
module bd2_merge (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     load,
	input  logic [bd2_pkg::CHAN_W-1:0]               avg [bd2_pkg::NUM_LANES],
	input  logic [bd2_pkg::COORD_W-1:0]              dest_x,
	input  logic [bd2_pkg::COORD_W-1:0]              dest_y,
	output logic                                     m_axis_tvalid,
	input  logic                                     m_axis_tready,
	// chan0_out, chan1_out, chan2_out, chan3_out, dest_x, dest_y, zero padding
	output logic [bd2_pkg::OUT_DATA_W-1:0]           m_axis_tdata,
	output logic                                     free
);
	import bd2_pkg::*;

	localparam int PAD_W = OUT_DATA_W - NUM_LANES * CHAN_W - 2 * COORD_W;

	logic                  valid_q;
	logic [OUT_DATA_W-1:0] data_q;
	logic [OUT_DATA_W-1:0] data_d;

	always_comb begin
		data_d = '0;
		for (int i = 0; i < NUM_LANES; i++) begin
			data_d[i*CHAN_W +: CHAN_W] = avg[i];
		end
		data_d[NUM_LANES*CHAN_W +: COORD_W]           = dest_x;
		data_d[NUM_LANES*CHAN_W + COORD_W +: COORD_W] = dest_y;
		data_d[OUT_DATA_W-1 -: PAD_W]                 = '0;
	end

	assign free          = !valid_q || m_axis_tready;
	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= data_d;
		end
	end

endmodule

/* design/box_downscale_2x2.sv */
// Top level of the 2x2 box-filter downscaler.
// Depends on bd2_pkg, bd2_ram, bd2_lane and bd2_merge.
//
// Source pixels enter on the s_axis channel in raster order, one beat per pixel,
// four 8-bit channels per beat. The frame size is set through cfg_we, cfg_index
// and cfg_data while the block is idle; index 0 is the width, index 1 the height.
// A beat at an odd column of an odd row gives one output beat on m_axis with the
// four channel means of its 2x2 block and the destination column and row.
// All other beats are absorbed and give nothing.
// Throughput is one pixel per clock while the receiver does not stall. An output
// beat is formed from its source beat through the line-store read and the middle
// stage, then held in the output register.
// When the receiver stalls, the block still takes one more producing beat into
// its middle stage and any number of non-producing beats, then holds s_axis_tready
// low until the output register drains.
// Reset clears the counters, sets both sizes to 2048 and empties the pipeline.
// The line store needs no clearing; each entry is written on an even row before
// the odd row reads it.
module box_downscale_2x2 #(
	parameter int MAX_WIDTH  = bd2_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bd2_pkg::DEF_MAX_HEIGHT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// chan0_in, chan1_in, chan2_in, chan3_in
	input  logic [bd2_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// chan0_out, chan1_out, chan2_out, chan3_out, dest_x, dest_y, zero padding
	output logic [bd2_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	input  logic                               cfg_we,
	input  logic [bd2_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bd2_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import bd2_pkg::*;

	localparam int CW         = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int RW         = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int LINE_DEPTH = MAX_WIDTH / 2;
	localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
	localparam int XCMP_W     = (CW + 1 > SIZE_W + 1) ? CW + 1 : SIZE_W + 1;
	localparam int YCMP_W     = (RW + 1 > SIZE_W + 1) ? RW + 1 : SIZE_W + 1;
	localparam int LINE_W     = NUM_LANES * SUM_W;

	logic [SIZE_W-1:0] frame_width_q;
	logic [SIZE_W-1:0] frame_height_q;
	logic [CW-1:0]     col_q;
	logic [RW-1:0]     row_q;

	logic [XCMP_W-1:0] eff_w;
	logic [YCMP_W-1:0] eff_h;
	logic              col_last;
	logic              row_last;

	logic              accept;
	logic              produce;
	logic              line_we;
	logic [AW-1:0]     line_addr;
	logic [LINE_W-1:0] line_wdata;
	logic [LINE_W-1:0] line_rdata;
	logic [CW-1:0]     col_half;
	logic [RW-1:0]     row_half;

	logic               valid_s1;
	logic [COORD_W-1:0] dest_x_s1;
	logic [COORD_W-1:0] dest_y_s1;
	logic               s1_move;
	logic               out_free;

	lane_ctrl_t        lane_ctrl;
	logic [SUM_W-1:0]  pair [NUM_LANES];
	logic [CHAN_W-1:0] avg  [NUM_LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= SIZE_RESET;
			frame_height_q <= SIZE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (frame_width_q == '0) begin
			eff_w = XCMP_W'(1);
		end else if (XCMP_W'(frame_width_q) > XCMP_W'(MAX_WIDTH)) begin
			eff_w = XCMP_W'(MAX_WIDTH);
		end else begin
			eff_w = XCMP_W'(frame_width_q);
		end
		if (frame_height_q == '0) begin
			eff_h = YCMP_W'(1);
		end else if (YCMP_W'(frame_height_q) > YCMP_W'(MAX_HEIGHT)) begin
			eff_h = YCMP_W'(MAX_HEIGHT);
		end else begin
			eff_h = YCMP_W'(frame_height_q);
		end
	end

	assign col_last = (XCMP_W'(col_q) + XCMP_W'(1)) >= eff_w;
	assign row_last = (YCMP_W'(row_q) + YCMP_W'(1)) >= eff_h;

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign produce       = col_q[0] && row_q[0];
	assign s1_move       = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_last ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	assign lane_ctrl.load_held = accept && !col_q[0];
	assign lane_ctrl.adv_s1    = accept && produce;

	assign col_half  = col_q >> 1;
	assign row_half  = row_q >> 1;
	assign line_addr = AW'(col_half);
	assign line_we   = accept && col_q[0] && !row_q[0];

	always_comb begin
		for (int i = 0; i < NUM_LANES; i++) begin
			line_wdata[i*SUM_W +: SUM_W] = pair[i];
		end
	end

	bd2_ram #(
		.WIDTH (LINE_W),
		.DEPTH (LINE_DEPTH),
		.ADDR_W(AW)
	) u_line (
		.clk  (clk),
		.we   (line_we),
		.waddr(line_addr),
		.wdata(line_wdata),
		.re   (lane_ctrl.adv_s1),
		.raddr(line_addr),
		.rdata(line_rdata)
	);

	for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
		bd2_lane u_lane (
			.clk  (clk),
			.ctrl (lane_ctrl),
			.px   (s_axis_tdata[g*CHAN_W +: CHAN_W]),
			.upper(line_rdata[g*SUM_W +: SUM_W]),
			.pair (pair[g]),
			.avg  (avg[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (lane_ctrl.adv_s1) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (lane_ctrl.adv_s1) begin
			dest_x_s1 <= COORD_W'(col_half);
			dest_y_s1 <= COORD_W'(row_half);
		end
	end

	bd2_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (s1_move),
		.avg          (avg),
		.dest_x       (dest_x_s1),
		.dest_y       (dest_y_s1),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.free         (out_free)
	);

endmodule

/* verif/box_downscale_2x2_tb.sv */
// Testbench for box_downscale_2x2: drives raster frames of several sizes through the stream ports
// and checks every output beat against a per-pixel prediction of the 2x2 block means.
// Depends on bd2_pkg and the design sources of box_downscale_2x2.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bd2_pkg::*;

	localparam int LINE_ENTRIES = DEF_MAX_WIDTH / 2;
	localparam int HOLD_CYCLES  = 60;
	localparam int DRAIN_CYCLES = 8;
	localparam int PAD_W        = OUT_DATA_W - 2 * COORD_W - NUM_LANES * CHAN_W;

	typedef struct packed {
		logic [PAD_W-1:0]                 pad;
		logic [COORD_W-1:0]               dest_y;
		logic [COORD_W-1:0]               dest_x;
		logic [NUM_LANES-1:0][CHAN_W-1:0] mean;
	} block_mean_t;

	class block_mean_board;
		logic [SIZE_W-1:0]        width_reg;
		logic [SIZE_W-1:0]        height_reg;
		logic [10:0]              column;
		logic [10:0]              row;
		logic [IN_DATA_W-1:0]     held_left;
		logic [4*SUM_W-1:0]       pair_sums [LINE_ENTRIES];
		block_mean_t              pending_means [$];
		int                       mismatches;
		int                       pixels_seen;
		int                       results_seen;

		function new();
			width_reg = SIZE_RESET;
			height_reg = SIZE_RESET;
			column = '0;
			row = '0;
			held_left = '0;
			foreach (pair_sums[i]) pair_sums[i] = '0;
			mismatches = 0;
			pixels_seen = 0;
			results_seen = 0;
		endfunction

		function int unsigned clamp_size(logic [SIZE_W-1:0] v, int unsigned limit);
			if (v == 0) return 1;
			if (v > limit) return limit;
			return v;
		endfunction

		function int unsigned frame_pixels();
			return clamp_size(width_reg, DEF_MAX_WIDTH) * clamp_size(height_reg, DEF_MAX_HEIGHT);
		endfunction

		function int pending();
			return pending_means.size();
		endfunction

		function void set_size(logic [CFG_IDX_W-1:0] index, logic [SIZE_W-1:0] value);
			if (index == REG_FRAME_WIDTH) begin
				width_reg = value;
			end else begin
				height_reg = value;
			end
		endfunction

		function void take_pixel(logic [IN_DATA_W-1:0] px);
			int unsigned        x;
			int unsigned        y;
			int unsigned        w;
			int unsigned        h;
			logic [SUM_W-1:0]   pair [NUM_LANES];
			logic [4*SUM_W-1:0] line_word;
			logic [SUM_W:0]     total;
			block_mean_t        r;
			x = column;
			y = row;
			w = clamp_size(width_reg, DEF_MAX_WIDTH);
			h = clamp_size(height_reg, DEF_MAX_HEIGHT);
			pixels_seen++;
			if (!column[0]) begin
				held_left = px;
			end else begin
				for (int c = 0; c < NUM_LANES; c++)
					pair[c] = {1'b0, held_left[CHAN_W*c +: CHAN_W]} + {1'b0, px[CHAN_W*c +: CHAN_W]};
				if (!row[0]) begin
					for (int c = 0; c < NUM_LANES; c++)
						line_word[SUM_W*c +: SUM_W] = pair[c];
					pair_sums[column[10:1]] = line_word;
				end else begin
					line_word = pair_sums[column[10:1]];
					r = '0;
					for (int c = 0; c < NUM_LANES; c++) begin
						total = {1'b0, line_word[SUM_W*c +: SUM_W]} + {1'b0, pair[c]};
						r.mean[c] = total[SUM_W:2];
					end
					r.dest_x = column[10:1];
					r.dest_y = row[10:1];
					pending_means.push_back(r);
				end
			end
			if (x + 1 >= w) begin
				column = '0;
				row = (y + 1 >= h) ? 11'd0 : 11'(y + 1);
			end else begin
				column = 11'(x + 1);
			end
		endfunction

		task report_mismatch(string what);
			mismatches++;
			if (mismatches <= 30) $display("MISMATCH at %0t ns: %s", $time, what);
		endtask

		task check_result(logic [OUT_DATA_W-1:0] beat);
			block_mean_t got;
			block_mean_t want;
			got = beat;
			results_seen++;
			if (pending_means.size() == 0) begin
				report_mismatch($sformatf("output beat %h with no block pending", beat));
				return;
			end
			want = pending_means.pop_front();
			for (int c = 0; c < NUM_LANES; c++)
				if (got.mean[c] !== want.mean[c])
					report_mismatch($sformatf("block (%0d,%0d) channel %0d: got %0d, want %0d",
						want.dest_x, want.dest_y, c, got.mean[c], want.mean[c]));
			if (got.dest_x !== want.dest_x)
				report_mismatch($sformatf("dest_x: got %0d, want %0d", got.dest_x, want.dest_x));
			if (got.dest_y !== want.dest_y)
				report_mismatch($sformatf("dest_y: got %0d, want %0d", got.dest_y, want.dest_y));
			if (got.pad !== '0)
				report_mismatch($sformatf("padding bits not zero in beat %h", beat));
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_FRAME_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	block_mean_board board = new();
	int  gap_pct = 0;
	int  stall_pct = 0;
	bit  calm = 1'b0;
	bit  hold_request = 1'b0;

	box_downscale_2x2 uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
			if (s_axis_tvalid && s_axis_tready) board.take_pixel(s_axis_tdata);
		end
	end

	// The output side accepts beats, with short random stalls and one long hold on request.
	initial begin
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!calm && $urandom_range(99) < stall_pct) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		#1_000_000;
		$display("** box_downscale_2x2: FAILED **");
		$finish;
	end

	task automatic send_pixel(input logic [IN_DATA_W-1:0] px);
		if (!calm && $urandom_range(99) < gap_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= px;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic send_random(input int unsigned count);
		repeat (count) send_pixel($urandom());
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [SIZE_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		board.set_size(index, value);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_frame(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
	endtask

	task automatic run_frames(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
			input int unsigned frames);
		set_frame(w, h);
		send_random(board.frame_pixels() * frames);
		settle();
	endtask

	initial begin
		int unsigned random_items;
		int unsigned frames;
		int          phases;
		random_items = 0;
		phases = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Full-scale and near-zero blocks; the second one truncates a sum of three to zero.
		set_frame(12'd4, 12'd2);
		send_pixel(32'hFFFF_FFFF);
		send_pixel(32'hFFFF_FFFF);
		send_pixel(32'h0000_0000);
		send_pixel(32'h0000_0000);
		send_pixel(32'hFFFF_FFFF);
		send_pixel(32'hFFFF_FFFF);
		send_pixel(32'h0000_0000);
		send_pixel(32'h0303_0303);
		settle();

		// The width shrinks in mid-row, so column six wraps at once; the frame then ends on
		// a trailing odd column and a trailing odd row.
		set_frame(12'd8, 12'd3);
		send_random(6);
		settle();
		write_reg(REG_FRAME_WIDTH, 12'd3);
		send_random(7);
		settle();

		// Zero sizes count as one pixel.
		run_frames(12'd0, 12'd0, 2);

		gap_pct = 10;
		stall_pct = 10;
		run_frames(12'd6, 12'd4, 1);
		run_frames(12'd2, 12'd7, 1);
		run_frames(12'd7, 12'd1, 1);
		run_frames(12'd1, 12'd5, 1);

		// Long output hold while the source keeps offering beats.
		gap_pct = 0;
		stall_pct = 0;
		hold_request = 1'b1;
		run_frames(12'd16, 12'd4, 1);

		while (random_items < 860) begin
			calm = (random_items >= 720);
			gap_pct = $urandom_range(3) * 12;
			stall_pct = $urandom_range(3) * 12;
			frames = $urandom_range(1, 2);
			phases++;
			set_frame(12'($urandom_range(24)), 12'($urandom_range(8)));
			random_items += board.frame_pixels() * frames;
			send_random(board.frame_pixels() * frames);
			settle();
		end

		$display("Run covered %0d source pixels and %0d output beats, %0d random frame sizes,",
			board.pixels_seen, board.results_seen, phases);
		$display("channel extremes, zero sizes, odd trailing edges, a mid-row width change and a long hold.");
		if (board.mismatches == 0) begin
			$display("** box_downscale_2x2: PASSED **");
		end else begin
			$display("** box_downscale_2x2: FAILED **");
		end
		$finish;
	end

endmodule
